>>> design/filter_stepper_and_count_gate_control_unit_defines.svh
// assertion macros shared by the filter stepper and count gate design
`ifndef FILTER_STEPPER_AND_COUNT_GATE_CONTROL_UNIT_DEFINES_SVH
`define FILTER_STEPPER_AND_COUNT_GATE_CONTROL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define FSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define FSC_ASSERT_IMPL(lbl, ante, cons)
`define FSC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/fsc_pkg.sv
// types, codes and constants for the filter stepper and count gate unit
package fsc_pkg;

    localparam int POS_W   = 16;
    localparam int CNT_W   = 16;
    localparam int VAL_W   = 17;
    localparam int REQ_W   = 3;
    localparam int CODE_W  = 2;

    localparam int TICK_RATE_HZ_DEF = 100;
    localparam int STEP_DIVISOR_DEF = 25;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RESET  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_START  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ENABLE = 3'd4;

    // count result codes
    localparam logic [CODE_W-1:0] CODE_NORMAL   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_OVERFLOW = 2'd1;
    localparam logic [CODE_W-1:0] CODE_TIMEOUT  = 2'd2;

    localparam logic [POS_W-1:0] HOME_POS   = 16'd400;
    localparam logic [VAL_W-1:0] OVF_LIMIT  = 17'd30000;
    localparam logic [VAL_W-1:0] FULL_COUNT = 17'h10000;

    // rate * ms stays below 2^26 for rates up to 1000
    localparam int MS_PER_S    = 1000;
    localparam int PROD_W      = 26;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 27;
    localparam logic [63:0] RECIP_64 =
        ((64'd1 << RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_64[RECIP_W-1:0];
    localparam int QUOT_W = PROD_W + RECIP_W;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [CNT_W-1:0] arg;
        logic [CNT_W-1:0] live_count;
        logic             gate_done;
        logic             pulses_seen;
        logic [CNT_W-1:0] latched_count;
    } t_req;

    typedef struct packed {
        logic              step_pulse;
        logic              step_dir;
        logic              counter_clear;
        logic              gate_start;
        logic [CNT_W-1:0]  gate_period;
        logic              filter_arrived;
        logic [POS_W-1:0]  position;
        logic              count_reply;
        logic [CODE_W-1:0] count_code;
        logic [VAL_W-1:0]  count_value;
        logic              moving;
        logic              integration_disabled;
    } t_res;

    typedef struct packed {
        logic             step_pulse;
        logic             step_dir;
        logic             filter_arrived;
        logic [POS_W-1:0] position;
        logic             moving;
        logic             integration_disabled;
    } t_step_out;

    typedef struct packed {
        logic              counter_clear;
        logic              gate_start;
        logic [CNT_W-1:0]  gate_period;
        logic              count_reply;
        logic [CODE_W-1:0] count_code;
        logic [VAL_W-1:0]  count_value;
    } t_gate_out;

endpackage

>>> design/fsc_chan_if.sv
// valid/ready channel interfaces for request and result beats
interface fsc_req_if;
    import fsc_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fsc_res_if;
    import fsc_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/filter_stepper_and_count_gate_control_unit.sv
// top level of the filter stepper and count gate controller
//
//  channel   dir  beat contents
//  i_req     in   req_type, arg, live_count, gate_done, pulses_seen, latched_count
//  o_res     out  step, gate, position, count reply and status fields
//
// one beat per cycle sustained while o_res.ready stays high
// an input register (with the gate-period product) feeds one pass of stepper and
// gate logic into the result register; state updates as a beat leaves the input stage
// i_req.ready drops only when both stages hold beats and o_res.ready is low
// synchronous active-low reset empties both stages and sets filter and gate state
`include "filter_stepper_and_count_gate_control_unit_defines.svh"
module filter_stepper_and_count_gate_control_unit #(
    parameter int TICK_RATE_HZ = fsc_pkg::TICK_RATE_HZ_DEF,
    parameter int STEP_DIVISOR = fsc_pkg::STEP_DIVISOR_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fsc_req_if.sink         i_req,
    fsc_res_if.source       o_res
);
    import fsc_pkg::*;

    logic              r_in_valid;
    t_req              r_in;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid;
    t_res              r_out;

    logic      w_adv;
    logic      w_take;
    t_step_out w_step;
    t_gate_out w_gate;
    t_res      w_res;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_take      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in   <= i_req.payload;
            r_prod <= PROD_W'(TICK_RATE_HZ) * PROD_W'(i_req.payload.arg);
        end
    end

    fsc_stepper #(
        .TICK_RATE_HZ (TICK_RATE_HZ),
        .STEP_DIVISOR (STEP_DIVISOR)
    ) u_stepper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (r_in),
        .o_step  (w_step)
    );

    fsc_gate u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (r_in),
        .i_prod  (r_prod),
        .o_gate  (w_gate)
    );

    always_comb begin
        w_res.step_pulse           = w_step.step_pulse;
        w_res.step_dir             = w_step.step_dir;
        w_res.counter_clear        = w_gate.counter_clear;
        w_res.gate_start           = w_gate.gate_start;
        w_res.gate_period          = w_gate.gate_period;
        w_res.filter_arrived       = w_step.filter_arrived;
        w_res.position             = w_step.position;
        w_res.count_reply          = w_gate.count_reply;
        w_res.count_code           = w_gate.count_code;
        w_res.count_value          = w_gate.count_value;
        w_res.moving               = w_step.moving;
        w_res.integration_disabled = w_step.integration_disabled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    `FSC_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid)
    `FSC_ASSERT_IMPL(a_stall_only_full, !i_req.ready, r_in_valid && r_out_valid && !o_res.ready)
    `FSC_ASSERT_IMPL(a_timeout_value_zero,
        o_res.valid && (o_res.payload.count_code == CODE_TIMEOUT),
        o_res.payload.count_reply && (o_res.payload.count_value == '0))
endmodule

>>> design/fsc_stepper.sv
// filter stepper: position, target, step pacing and move enable
`include "filter_stepper_and_count_gate_control_unit_defines.svh"
module fsc_stepper #(
    parameter int TICK_RATE_HZ = fsc_pkg::TICK_RATE_HZ_DEF,
    parameter int STEP_DIVISOR = fsc_pkg::STEP_DIVISOR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fsc_pkg::t_req     i_req,
    output fsc_pkg::t_step_out o_step
);
    import fsc_pkg::*;

    localparam int TPS_RAW = TICK_RATE_HZ / STEP_DIVISOR;
    localparam logic [POS_W-1:0] TICKS_PER_STEP = POS_W'((TPS_RAW > 0) ? TPS_RAW : 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_tgt, n_tgt;
    logic             r_move, n_move;
    logic [POS_W-1:0] r_cd, n_cd;
    logic             r_allowed, n_allowed;
    logic             r_dis, n_dis;

    logic [POS_W-1:0] w_fpos;
    logic [POS_W-1:0] w_ftgt;
    logic             w_do;
    logic             w_tick;
    logic             w_pulse;
    logic             w_dir;
    logic             w_arrived;

    always_comb begin
        n_tgt     = r_tgt;
        n_cd      = r_cd;
        n_allowed = r_allowed;
        n_dis     = r_dis;
        w_fpos    = r_pos;
        w_ftgt    = r_tgt;
        w_do      = 1'b0;
        w_tick    = 1'b0;
        case (i_req.req_type)
            REQ_TICK: begin
                w_tick = 1'b1;
                w_do   = r_move && (r_cd == '0);
                n_cd   = r_cd - 1'b1;
            end
            REQ_RESET: begin
                w_fpos = HOME_POS;
                w_ftgt = '0;
                n_tgt  = '0;
                w_do   = 1'b1;
            end
            REQ_MOVE: begin
                if (r_allowed) begin
                    w_ftgt = i_req.arg;
                    n_tgt  = i_req.arg;
                    w_do   = 1'b1;
                end
            end
            REQ_ENABLE: begin
                n_allowed = (i_req.arg != '0);
                if (i_req.arg != '0) begin
                    n_dis = 1'b0;
                end else begin
                    n_dis  = 1'b1;
                    n_tgt  = '0;
                    w_ftgt = '0;
                    w_do   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // one step toward the target, or arrival
        n_pos     = w_fpos;
        n_move    = r_move;
        w_pulse   = 1'b0;
        w_dir     = 1'b0;
        w_arrived = 1'b0;
        if (w_do) begin
            if (w_fpos < w_ftgt) begin
                w_pulse = 1'b1;
                n_pos   = w_fpos + 1'b1;
                n_move  = 1'b1;
            end else if (w_fpos > w_ftgt) begin
                w_pulse = 1'b1;
                w_dir   = 1'b1;
                n_pos   = w_fpos - 1'b1;
                n_move  = 1'b1;
            end else begin
                n_move    = 1'b0;
                w_arrived = 1'b1;
            end
            // a tick reloads the countdown and then counts it down once
            if (w_pulse) begin
                n_cd = w_tick ? TICKS_PER_STEP - 1'b1 : TICKS_PER_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= HOME_POS;
            r_tgt     <= '0;
            r_move    <= 1'b1;
            r_cd      <= TICKS_PER_STEP;
            r_allowed <= 1'b0;
            r_dis     <= 1'b0;
        end else if (i_en) begin
            r_pos     <= n_pos;
            r_tgt     <= n_tgt;
            r_move    <= n_move;
            r_cd      <= n_cd;
            r_allowed <= n_allowed;
            r_dis     <= n_dis;
        end
    end

    assign o_step.step_pulse           = w_pulse;
    assign o_step.step_dir             = w_dir;
    assign o_step.filter_arrived       = w_arrived;
    assign o_step.position             = n_pos;
    assign o_step.moving               = n_move;
    assign o_step.integration_disabled = n_dis;

    `FSC_ASSERT_IMPL(a_pulse_not_arrived, !(w_pulse && w_arrived), 1'b1)
    `FSC_ASSERT_NEXT(a_step_keeps_moving, i_en && w_pulse, r_move)
    `FSC_ASSERT_NEXT(a_arrive_stops, i_en && w_arrived, !r_move && (r_pos == r_tgt))
endmodule

>>> design/fsc_gate.sv
// count gate: overflow watch, integration countdown and readout
`include "filter_stepper_and_count_gate_control_unit_defines.svh"
module fsc_gate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  fsc_pkg::t_req               i_req,
    input  logic [fsc_pkg::PROD_W-1:0]  i_prod,
    output fsc_pkg::t_gate_out          o_gate
);
    import fsc_pkg::*;

    logic [CNT_W-1:0] r_ms, n_ms;
    logic [CNT_W-1:0] r_ticks, n_ticks;
    logic [CNT_W-1:0] r_gc, n_gc;
    logic             r_running, n_running;
    logic             r_ovf, n_ovf;

    logic [QUOT_W-1:0] w_quot;
    logic [CNT_W-1:0]  w_ticks;
    logic              w_ovf_now;
    logic              w_ovf_cur;
    logic              w_start;
    logic              w_reply;
    logic [CODE_W-1:0] w_code;
    logic [VAL_W-1:0]  w_value;

    // gate ticks = rate * ms / 1000, by reciprocal multiply
    assign w_quot  = QUOT_W'(i_prod) * QUOT_W'(RECIP);
    assign w_ticks = w_quot[RECIP_SHIFT +: CNT_W];

    assign w_ovf_now = (i_req.req_type == REQ_TICK) &&
                       ((FULL_COUNT - {1'b0, i_req.live_count}) > OVF_LIMIT);
    assign w_ovf_cur = r_ovf || w_ovf_now;

    always_comb begin
        n_ms      = r_ms;
        n_ticks   = r_ticks;
        n_gc      = r_gc;
        n_running = r_running;
        n_ovf     = w_ovf_cur;
        w_start   = 1'b0;
        w_reply   = 1'b0;
        w_code    = CODE_NORMAL;
        w_value   = '0;
        case (i_req.req_type)
            REQ_TICK: begin
                if (r_running) begin
                    if (r_gc == '0) begin
                        if (!i_req.gate_done) begin
                            w_reply   = 1'b1;
                            w_code    = CODE_TIMEOUT;
                            n_running = 1'b0;
                        end else begin
                            if (i_req.pulses_seen) begin
                                w_reply = 1'b1;
                                w_code  = w_ovf_cur ? CODE_OVERFLOW : CODE_NORMAL;
                                w_value = FULL_COUNT - {1'b0, i_req.latched_count};
                            end
                            w_start = 1'b1;
                            n_gc    = r_ticks - 1'b1;
                        end
                    end else begin
                        n_gc = r_gc - 1'b1;
                    end
                end
            end
            REQ_START: begin
                n_ms      = i_req.arg;
                n_ticks   = w_ticks;
                n_gc      = w_ticks;
                n_running = 1'b1;
                w_start   = 1'b1;
            end
            default: begin
            end
        endcase
        if (w_start) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms      <= '0;
            r_ticks   <= '0;
            r_gc      <= '0;
            r_running <= 1'b1;
            r_ovf     <= 1'b0;
        end else if (i_en) begin
            r_ms      <= n_ms;
            r_ticks   <= n_ticks;
            r_gc      <= n_gc;
            r_running <= n_running;
            r_ovf     <= n_ovf;
        end
    end

    assign o_gate.counter_clear = w_ovf_now || w_start;
    assign o_gate.gate_start    = w_start;
    assign o_gate.gate_period   = w_start ? n_ms : '0;
    assign o_gate.count_reply   = w_reply;
    assign o_gate.count_code    = w_code;
    assign o_gate.count_value   = w_value;

    `FSC_ASSERT_NEXT(a_timeout_stops, i_en && w_reply && (w_code == CODE_TIMEOUT), !r_running)
    `FSC_ASSERT_NEXT(a_start_clears_ovf, i_en && w_start, !r_ovf && r_running)
    `FSC_ASSERT_IMPL(a_no_start_on_timeout, w_start, w_code != CODE_TIMEOUT)
endmodule

>>> tb/fsc_result_check.sv
// result checker: predicts each result beat of the filter stepper and count gate unit
module fsc_result_check #(
    parameter int TICK_RATE_HZ = fsc_pkg::TICK_RATE_HZ_DEF,
    parameter int STEP_DIVISOR = fsc_pkg::STEP_DIVISOR_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fsc_req_if   req_mon,
    fsc_res_if   res_mon,
    output int   o_pending,
    output int   o_mismatches,
    output int   o_checked,
    output int   o_replies,
    output int   o_arrivals
);
    import fsc_pkg::*;

    localparam int STEP_TICKS =
        (TICK_RATE_HZ / STEP_DIVISOR) > 0 ? (TICK_RATE_HZ / STEP_DIVISOR) : 1;

    // predicted controller state
    logic [POS_W-1:0] pos_q;
    logic [POS_W-1:0] target_q;
    logic             moving_q;
    logic [15:0]      step_cnt_q;
    logic             moves_en_q;
    logic             disabled_q;
    logic [CNT_W-1:0] gate_ms_q;
    logic [15:0]      gate_cnt_q;
    logic             gate_run_q;
    logic             ovf_q;

    t_res pending_results[$];
    t_res want;
    int   mismatches = 0;
    int   checked = 0;
    int   replies = 0;
    int   arrivals = 0;

    assign o_mismatches = mismatches;
    assign o_checked    = checked;
    assign o_replies    = replies;
    assign o_arrivals   = arrivals;

    function automatic void clear_state();
        pos_q      = HOME_POS;
        target_q   = '0;
        moving_q   = 1'b1;
        step_cnt_q = 16'(STEP_TICKS);
        moves_en_q = 1'b0;
        disabled_q = 1'b0;
        gate_ms_q  = '0;
        gate_cnt_q = '0;
        gate_run_q = 1'b1;
        ovf_q      = 1'b0;
    endfunction

    // one step toward the target, or flag arrival when already there
    function automatic void step_filter(inout t_res e);
        if (pos_q == target_q) begin
            moving_q         = 1'b0;
            e.filter_arrived = 1'b1;
        end else begin
            e.step_pulse = 1'b1;
            e.step_dir   = (pos_q > target_q);
            pos_q        = (pos_q > target_q) ? pos_q - 1'b1 : pos_q + 1'b1;
            moving_q     = 1'b1;
            step_cnt_q   = 16'(STEP_TICKS);
        end
    endfunction

    function automatic void open_gate(inout t_res e);
        e.counter_clear = 1'b1;
        e.gate_start    = 1'b1;
        e.gate_period   = gate_ms_q;
        ovf_q           = 1'b0;
        gate_cnt_q      = 16'((TICK_RATE_HZ * gate_ms_q) / MS_PER_S);
        gate_run_q      = 1'b1;
    endfunction

    function automatic void read_gate(inout t_res e, input t_req r);
        if (!r.gate_done) begin
            // timeout stops integration until the next start
            e.count_reply = 1'b1;
            e.count_code  = CODE_TIMEOUT;
            e.count_value = '0;
            gate_run_q    = 1'b0;
        end else begin
            if (r.pulses_seen) begin
                e.count_reply = 1'b1;
                e.count_code  = ovf_q ? CODE_OVERFLOW : CODE_NORMAL;
                e.count_value = FULL_COUNT - {1'b0, r.latched_count};
            end
            open_gate(e);
        end
    endfunction

    function automatic t_res predict_result(input t_req r);
        t_res e;
        e = '0;
        case (r.req_type)
            REQ_TICK: begin
                if (FULL_COUNT - {1'b0, r.live_count} > OVF_LIMIT) begin
                    e.counter_clear = 1'b1;
                    ovf_q           = 1'b1;
                end
                if (moving_q && step_cnt_q == 0)
                    step_filter(e);
                step_cnt_q = step_cnt_q - 1'b1;
                if (gate_run_q) begin
                    if (gate_cnt_q == 0)
                        read_gate(e, r);
                    if (gate_run_q)
                        gate_cnt_q = gate_cnt_q - 1'b1;
                end
            end
            REQ_RESET: begin
                pos_q    = HOME_POS;
                target_q = '0;
                step_filter(e);
            end
            REQ_START: begin
                gate_ms_q = r.arg;
                open_gate(e);
            end
            REQ_MOVE: begin
                if (moves_en_q) begin
                    target_q = r.arg;
                    step_filter(e);
                end
            end
            REQ_ENABLE: begin
                moves_en_q = (r.arg != 0);
                if (moves_en_q) begin
                    disabled_q = 1'b0;
                end else begin
                    disabled_q = 1'b1;
                    target_q   = '0;
                    step_filter(e);
                end
            end
            default: ;
        endcase
        e.position             = pos_q;
        e.moving               = moving_q;
        e.integration_disabled = disabled_q;
        return e;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            pending_results.delete();
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("step_pulse", want.step_pulse, res_mon.payload.step_pulse);
                    check_field("step_dir", want.step_dir, res_mon.payload.step_dir);
                    check_field("counter_clear", want.counter_clear,
                                res_mon.payload.counter_clear);
                    check_field("gate_start", want.gate_start, res_mon.payload.gate_start);
                    check_field("gate_period", want.gate_period, res_mon.payload.gate_period);
                    check_field("filter_arrived", want.filter_arrived,
                                res_mon.payload.filter_arrived);
                    check_field("position", want.position, res_mon.payload.position);
                    check_field("count_reply", want.count_reply, res_mon.payload.count_reply);
                    check_field("count_code", want.count_code, res_mon.payload.count_code);
                    check_field("count_value", want.count_value, res_mon.payload.count_value);
                    check_field("moving", want.moving, res_mon.payload.moving);
                    check_field("integration_disabled", want.integration_disabled,
                                res_mon.payload.integration_disabled);
                    checked++;
                    if (want.count_reply)
                        replies++;
                    if (want.filter_arrived)
                        arrivals++;
                end
            end
            if (req_mon.valid && req_mon.ready)
                pending_results.push_back(predict_result(req_mon.payload));
        end
        o_pending <= pending_results.size();
    end

endmodule

>>> tb/tb.sv
// testbench top: request stimulus, result back-pressure and the final verdict
module tb;
    import fsc_pkg::*;

    localparam int TICK_HZ  = TICK_RATE_HZ_DEF;
    localparam int STEP_DIV = STEP_DIVISOR_DEF;
    localparam int RANDOM_BEATS = 650;

    // request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;
    localparam logic [POS_W-1:0] MOVE_AIM = HOME_POS;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsc_req_if req_bus();
    fsc_res_if res_bus();

    int pending;
    int mismatches;
    int checked;
    int replies;
    int arrivals;

    bit burst = 1'b0;
    bit moves_on = 1'b0;
    bit drained = 1'b0;
    int sent = 0;
    int ticks_sent = 0;
    int useful = 0;

    filter_stepper_and_count_gate_control_unit #(
        .TICK_RATE_HZ(TICK_HZ),
        .STEP_DIVISOR(STEP_DIV)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_res  (res_bus)
    );

    fsc_result_check #(
        .TICK_RATE_HZ(TICK_HZ),
        .STEP_DIVISOR(STEP_DIV)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req_mon     (req_bus),
        .res_mon     (res_bus),
        .o_pending   (pending),
        .o_mismatches(mismatches),
        .o_checked   (checked),
        .o_replies   (replies),
        .o_arrivals  (arrivals)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

    // offer one request beat and hold it until the block takes it
    task automatic send_beat(input t_req r);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.payload <= r;
        do @(posedge i_clk); while (!req_bus.ready);
        sent++;
        if (r.req_type == REQ_TICK)
            ticks_sent++;
        if (r.req_type == REQ_ENABLE)
            moves_on = (r.arg != 0);
    endtask

    task automatic send_fields(input logic [REQ_W-1:0] kind, input logic [15:0] arg,
                               input logic [15:0] live, input bit done, input bit seen,
                               input logic [15:0] latched);
        t_req r;
        r.req_type      = kind;
        r.arg           = arg;
        r.live_count    = live;
        r.gate_done     = done;
        r.pulses_seen   = seen;
        r.latched_count = latched;
        send_beat(r);
    endtask

    // mostly well-formed traffic: short gates, moves near the home position
    function automatic t_req next_request();
        t_req r;
        int pick;
        int roll;
        r.req_type      = REQ_TICK;
        r.arg           = 16'($urandom);
        r.live_count    = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(35536, 65535))
                                                       : 16'($urandom);
        r.gate_done     = ($urandom_range(0, 99) < 92);
        r.pulses_seen   = ($urandom_range(0, 99) < 85);
        r.latched_count = 16'($urandom);
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (pick < 50) begin
            r.req_type = REQ_TICK;
        end else if (pick < 60) begin
            r.req_type = REQ_START;
            if (roll < 75)
                r.arg = 16'($urandom_range(10, 60));
            else if (roll < 92)
                r.arg = 16'($urandom_range(0, 9));
        end else if (pick < 80) begin
            r.req_type = REQ_MOVE;
            if (roll < 80)
                r.arg = 16'(MOVE_AIM + $urandom_range(0, 10) - 5);
        end else if (pick < 87) begin
            r.req_type = REQ_ENABLE;
            r.arg = (roll < 25) ? 16'd0 : 16'($urandom_range(1, 65535));
        end else if (pick < 92) begin
            r.req_type = REQ_RESET;
        end else begin
            r.req_type = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
        end
        return r;
    endfunction

    // result side: random stalls, one long hold-off, one stretch with no stalls
    initial begin
        int stall;
        int got;
        got = 0;
        res_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (got == 310)
                stall = 60;
            else if (got >= 500 && got < 600)
                stall = 0;
            else
                stall = $urandom_range(0, 6);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
            got++;
        end
    end

    initial begin
        t_req r;
        req_bus.valid   = 1'b0;
        req_bus.payload = '0;
        i_rst_n         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first readout, overflow threshold, ignored requests, moves, gates
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_TICK, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF);
        send_fields(REQ_TICK, 16'h0000, 16'd35535, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_TICK, 16'h0000, 16'd35536, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        send_fields(REQ_FIRST_UNUSED + 3'd1, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_fields(REQ_LAST_UNUSED, 16'hA5A5, 16'h5A5A, 1'b1, 1'b0, 16'h1234);
        send_fields(REQ_MOVE, 16'd123, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_ENABLE, 16'h8000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_MOVE, MOVE_AIM, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_MOVE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_MOVE, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_ENABLE, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_RESET, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_START, 16'd10, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_TICK, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        // readout with no pulses: no reply, gate restarts
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 16'h0000);
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        // gate timeout, then integration stays stopped
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'h0000);
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_START, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_fields(REQ_START, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        // zero-length gate read out and restarted with a wrapping countdown
        send_fields(REQ_TICK, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'd12345);

        while (useful < RANDOM_BEATS) begin
            burst = (useful >= 300 && useful < 380) || (useful >= 600 && useful < 680);
            if (useful == 450 && !drained) begin
                drained = 1'b1;
                req_bus.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            r = next_request();
            if (r.req_type <= REQ_ENABLE && !(r.req_type == REQ_MOVE && !moves_on))
                useful++;
            send_beat(r);
        end
        req_bus.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("run summary: %0d request beats (%0d ticks), %0d result beats checked",
                 sent, ticks_sent, checked);
        $display("run summary: %0d count replies, %0d filter arrivals, %0d mismatches",
                 replies, arrivals, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
